>>> design/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg: shared types and constants for the charge deposit block
// Field widths, request and register codes, the control word layout and
// the microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
`default_nettype none

package ccd_pkg;

  // Default sizes
  localparam int GRID_X_DEF    = 64;
  localparam int GRID_Y_DEF    = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Field widths
  localparam int REQ_W      = 2;
  localparam int POS_W      = 32;
  localparam int INV_W      = 24;
  localparam int START_W    = 20;
  localparam int WGT_W      = 16;
  localparam int IDX_W      = 6;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Fixed-point layout of the coordinate product (Q12.20 times Q8.16)
  localparam int POS_FRAC   = 20;
  localparam int INV_FRAC   = 16;
  localparam int COORD_FRAC = POS_FRAC + INV_FRAC;
  localparam int PROD_W     = POS_W + INV_W;
  localparam int WHOLE_W    = PROD_W - COORD_FRAC;

  // Register reset values
  localparam logic [INV_W-1:0]   INV_RESET   = INV_W'(65536);
  localparam logic [START_W-1:0] START_RESET = '0;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_DEPOSIT = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RDCLR   = 2'd2
  } req_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_X   = 2'd0,
    CFG_INV_Y   = 2'd1,
    CFG_START_X = 2'd2,
    CFG_START_Y = 2'd3
  } cfg_idx_e;

  // Microprogram steps
  typedef enum logic [3:0] {
    ST_CLR   = 4'd0,
    ST_IDLE  = 4'd1,
    ST_DISP  = 4'd2,
    ST_DEPY  = 4'd3,
    ST_CELLA = 4'd4,
    ST_CELLB = 4'd5,
    ST_CELLC = 4'd6,
    ST_FIN   = 4'd7,
    ST_RD0   = 4'd8,
    ST_RD1   = 4'd9
  } step_e;

  // Jump conditions
  typedef enum logic [2:0] {
    J_NEXT      = 3'd0,
    J_ALWAYS    = 3'd1,
    J_NO_ACC    = 3'd2,
    J_DISPATCH  = 3'd3,
    J_CELL_MORE = 3'd4,
    J_CLR_MORE  = 3'd5
  } jmp_e;

  // One control word
  typedef struct packed {
    logic  in_rdy;    // may take a transfer on the input channel
    logic  loc_x;     // locate x: coordinate multiply on x
    logic  loc_y;     // locate y: coordinate multiply on y
    logic  cell_rd;   // cell address, range check, shape product, grid read
    logic  wmul;      // weight multiply and rounding
    logic  acc_wr;    // saturating add and write back, next cell
    logic  rd_issue;  // read request: address and grid read
    logic  rd_done;   // read request: capture value, clear if asked
    logic  clr_wr;    // clearing pass write
    logic  finish;    // result complete
    jmp_e  jmp;
    step_e tgt;
  } ctl_t;

  // Status from the datapath for conditional jumps
  typedef struct packed {
    logic cell_more;
    logic clr_more;
    req_e req;
  } stat_t;

  // Result of one request
  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             oor;
    logic             sat;
  } res_t;

  // Microprogram ROM
  function automatic ctl_t ccd_ucode(step_e s);
    ctl_t c;
    c     = '0;
    c.jmp = J_NEXT;
    c.tgt = ST_IDLE;
    case (s)
      ST_CLR: begin
        c.clr_wr = 1'b1;
        c.jmp    = J_CLR_MORE;
        c.tgt    = ST_CLR;
      end
      ST_IDLE: begin
        c.in_rdy = 1'b1;
        c.jmp    = J_NO_ACC;
        c.tgt    = ST_IDLE;
      end
      ST_DISP: begin
        c.loc_x = 1'b1;
        c.jmp   = J_DISPATCH;
      end
      ST_DEPY: begin
        c.loc_y = 1'b1;
      end
      ST_CELLA: begin
        c.cell_rd = 1'b1;
      end
      ST_CELLB: begin
        c.wmul = 1'b1;
      end
      ST_CELLC: begin
        c.acc_wr = 1'b1;
        c.jmp    = J_CELL_MORE;
        c.tgt    = ST_CELLA;
      end
      ST_FIN: begin
        c.finish = 1'b1;
        c.jmp    = J_ALWAYS;
        c.tgt    = ST_IDLE;
      end
      ST_RD0: begin
        c.rd_issue = 1'b1;
      end
      ST_RD1: begin
        c.rd_done = 1'b1;
        c.jmp     = J_ALWAYS;
        c.tgt     = ST_FIN;
      end
      default: begin
        c.jmp = J_ALWAYS;
        c.tgt = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/ccd_ram.sv
// ----------------------------------------------------------------------------
// ccd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/ccd_seq.sv
// ----------------------------------------------------------------------------
// ccd_seq: microprogram sequencer
// Step counter over the control ROM with conditional jumps on status.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire ccd_pkg::stat_t stat_i,
  output ccd_pkg::ctl_t      ctl_o
);

  import ccd_pkg::*;

  step_e step_q, step_d;
  step_e step_inc;
  ctl_t  ctl;

  // Control word of the current step
  always_comb begin
    ctl = ccd_ucode(step_q);
  end

  assign ctl_o    = ctl;
  assign step_inc = step_e'(step_q + 4'd1);

  // Next step
  always_comb begin
    step_d = step_inc;
    case (ctl.jmp)
      J_NEXT:      step_d = step_inc;
      J_ALWAYS:    step_d = ctl.tgt;
      J_NO_ACC:    step_d = accept_i ? step_inc : ctl.tgt;
      J_DISPATCH: begin
        case (stat_i.req)
          REQ_DEPOSIT: step_d = ST_DEPY;
          REQ_READ:    step_d = ST_RD0;
          REQ_RDCLR:   step_d = ST_RD0;
          default:     step_d = ST_FIN;
        endcase
      end
      J_CELL_MORE: step_d = stat_i.cell_more ? ctl.tgt : step_inc;
      J_CLR_MORE:  step_d = stat_i.clr_more ? ctl.tgt : step_inc;
      default:     step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_CLR;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

>>> design/ccd_datapath.sv
// ----------------------------------------------------------------------------
// ccd_datapath: deposit and read datapath
// Coordinate multiplier, shape and weight multipliers, cell addressing,
// saturating accumulate and the charge grid memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ccd_datapath #(
  parameter int GRID_X    = ccd_pkg::GRID_X_DEF,
  parameter int GRID_Y    = ccd_pkg::GRID_Y_DEF,
  parameter int FRAC_BITS = ccd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ccd_pkg::ctl_t                 ctl_i,
  input  wire logic                          accept_i,
  input  wire logic [ccd_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [ccd_pkg::POS_W-1:0]     x_pos_i,
  input  wire logic [ccd_pkg::POS_W-1:0]     y_pos_i,
  input  wire logic [ccd_pkg::WGT_W-1:0]     particle_weight_i,
  input  wire logic [ccd_pkg::IDX_W-1:0]     read_col_i,
  input  wire logic [ccd_pkg::IDX_W-1:0]     read_row_i,
  input  wire logic [ccd_pkg::INV_W-1:0]     inv_x_i,
  input  wire logic [ccd_pkg::INV_W-1:0]     inv_y_i,
  input  wire logic [ccd_pkg::START_W-1:0]   start_x_i,
  input  wire logic [ccd_pkg::START_W-1:0]   start_y_i,
  output ccd_pkg::stat_t                     stat_o,
  output ccd_pkg::res_t                      res_o
);

  import ccd_pkg::*;

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(GRID_X);
  localparam int CYW   = $clog2(GRID_Y);
  localparam int SW    = FRAC_BITS + 1;        // shape factor, up to 1.0
  localparam int PW    = 2 * FRAC_BITS + 1;    // Sx*Sy, up to 1.0
  localparam int MW    = PW + WGT_W;           // Sx*Sy*w plus rounding
  localparam int ADD_W = MW - 2 * FRAC_BITS;   // contribution, Q.16
  localparam int CW    = WHOLE_W + 2;          // signed local cell index

  localparam logic [SW-1:0] ONE  = SW'(1) << FRAC_BITS;
  localparam logic [MW-1:0] HALF = MW'(1) << (2 * FRAC_BITS - 1);

  // Request registers, loaded on an input transfer
  logic [REQ_W-1:0] req_q;
  logic [POS_W-1:0] x_q, y_q;
  logic [WGT_W-1:0] w_q;
  logic [IDX_W-1:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_type_i;
      x_q   <= x_pos_i;
      y_q   <= y_pos_i;
      w_q   <= particle_weight_i;
      col_q <= read_col_i;
      row_q <= read_row_i;
    end
  end

  // Coordinate multiplier, shared by x and y
  logic [POS_W-1:0]     pos_sel;
  logic [INV_W-1:0]     inv_sel;
  logic [PROD_W-1:0]    prod;
  logic [WHOLE_W-1:0]   wx_q, wy_q;
  logic [FRAC_BITS-1:0] dx_q, dy_q;

  assign pos_sel = ctl_i.loc_y ? y_q : x_q;
  assign inv_sel = ctl_i.loc_y ? inv_y_i : inv_x_i;
  assign prod    = pos_sel * inv_sel;

  always_ff @(posedge clk_i) begin
    if (ctl_i.loc_x) begin
      wx_q <= prod[PROD_W-1:COORD_FRAC];
      dx_q <= prod[COORD_FRAC-1 -: FRAC_BITS];
    end
    if (ctl_i.loc_y) begin
      wy_q <= prod[PROD_W-1:COORD_FRAC];
      dy_q <= prod[COORD_FRAC-1 -: FRAC_BITS];
    end
  end

  // Cell counter: bit 1 picks the x neighbor, bit 0 the y neighbor
  logic [1:0] k_q;
  logic       ofs_a, ofs_b;

  assign ofs_a = k_q[1];
  assign ofs_b = k_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (accept_i) begin
      k_q <= '0;
    end else if (ctl_i.acc_wr) begin
      k_q <= k_q + 2'd1;
    end
  end

  // Local cell index and range check for the current neighbor
  logic [CW-1:0] colv, rowv;
  logic          col_ok, row_ok, rd_ok;

  assign colv = {2'b00, wx_q} + CW'(ofs_a) - {2'b00, start_x_i};
  assign rowv = {2'b00, wy_q} + CW'(ofs_b) - {2'b00, start_y_i};

  assign col_ok = !colv[CW-1] && (colv[CW-2:0] < (CW-1)'(GRID_X));
  assign row_ok = !rowv[CW-1] && (rowv[CW-2:0] < (CW-1)'(GRID_Y));
  assign rd_ok  = (32'(col_q) < GRID_X) && (32'(row_q) < GRID_Y);

  // Grid address, from the deposit neighbor or the read request
  logic [CXW-1:0] col_idx;
  logic [CYW-1:0] row_idx;
  logic [AW-1:0]  addr;

  assign col_idx = ctl_i.rd_issue ? CXW'(col_q) : CXW'(colv);
  assign row_idx = ctl_i.rd_issue ? CYW'(row_q) : CYW'(rowv);
  assign addr    = AW'(row_idx * GRID_X + col_idx);

  // Shape factors and their product
  logic [SW-1:0]   sx, sy;
  logic [2*SW-1:0] sxy;
  logic [PW-1:0]   s_q;

  assign sx  = ofs_a ? {1'b0, dx_q} : ONE - {1'b0, dx_q};
  assign sy  = ofs_b ? {1'b0, dy_q} : ONE - {1'b0, dy_q};
  assign sxy = sx * sy;

  logic [AW-1:0] addr_q;
  logic          inr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cell_rd) begin
      addr_q <= addr;
      inr_q  <= col_ok && row_ok;
      s_q    <= sxy[PW-1:0];
    end else if (ctl_i.rd_issue) begin
      addr_q <= addr;
      inr_q  <= rd_ok;
    end
  end

  // Weight multiply with round half up
  logic [MW-1:0]    prodw;
  logic [ADD_W-1:0] add_q;

  assign prodw = s_q * w_q + HALF;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wmul) begin
      add_q <= prodw[MW-1:2*FRAC_BITS];
    end
  end

  // Saturating accumulate
  logic [ACC_W-1:0] rdata;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] sum_sat;

  assign sum     = {1'b0, rdata} + (ACC_W+1)'(add_q);
  assign sum_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

  // Clearing pass counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // Grid write port: clearing pass, accumulate, or read-and-clear
  logic             we;
  logic [AW-1:0]    waddr;
  logic [ACC_W-1:0] wdata;

  assign we    = ctl_i.clr_wr || (ctl_i.acc_wr && inr_q) ||
                 (ctl_i.rd_done && inr_q && (req_q == REQ_RDCLR));
  assign waddr = ctl_i.clr_wr ? clr_cnt_q : addr_q;
  assign wdata = ctl_i.acc_wr ? sum_sat : '0;

  ccd_ram #(
    .WIDTH(ACC_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl_i.cell_rd || ctl_i.rd_issue),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // Result of the request in progress
  logic [ACC_W-1:0] res_value_q;
  logic             res_oor_q, res_sat_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_value_q <= '0;
      res_oor_q   <= 1'b0;
      res_sat_q   <= 1'b0;
    end else if (ctl_i.acc_wr) begin
      res_oor_q <= res_oor_q | !inr_q;
      res_sat_q <= res_sat_q | (inr_q & sum[ACC_W]);
    end else if (ctl_i.rd_done) begin
      res_value_q <= inr_q ? rdata : '0;
      res_oor_q   <= !inr_q;
    end
  end

  assign res_o.value = res_value_q;
  assign res_o.oor   = res_oor_q;
  assign res_o.sat   = res_sat_q;

  // Status for the sequencer
  assign stat_o.cell_more = (k_q != 2'd3);
  assign stat_o.clr_more  = (clr_cnt_q != AW'(DEPTH - 1));
  assign stat_o.req       = req_e'(req_q);

endmodule

`default_nettype wire

>>> design/cic_charge_deposit_2d_top.sv
// ----------------------------------------------------------------------------
// cic_charge_deposit_2d_top: 2-D cloud-in-cell charge deposition
// First-order deposit of weighted particles into a saturating grid of
// charge accumulators, with cell read and read-and-clear requests.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   req_type, x_pos, y_pos,
//                                         particle_weight, read_col, read_row
//   out      out  out_valid_o/out_stall_i cell_value, out_of_range, saturated
//   cfg      in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A deposit visits four neighbor cells: the sequencer spends three
// steps per neighbor cell on the read-modify-write through the grid
// memory. A read passes through the steps ST_RD0 and ST_RD1; an unknown
// request goes straight to ST_FIN. After reset a clearing pass zeroes all
// GRID_X*GRID_Y cells (4096 by default) before the first transfer. One
// result waits in the output register while the next one is worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_charge_deposit_2d_top #(
  parameter int GRID_X    = ccd_pkg::GRID_X_DEF,
  parameter int GRID_Y    = ccd_pkg::GRID_Y_DEF,
  parameter int FRAC_BITS = ccd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ccd_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [ccd_pkg::POS_W-1:0]       x_pos_i,
  input  wire logic [ccd_pkg::POS_W-1:0]       y_pos_i,
  input  wire logic [ccd_pkg::WGT_W-1:0]       particle_weight_i,
  input  wire logic [ccd_pkg::IDX_W-1:0]       read_col_i,
  input  wire logic [ccd_pkg::IDX_W-1:0]       read_row_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [ccd_pkg::ACC_W-1:0]       cell_value_o,
  output logic                                 out_of_range_o,
  output logic                                 saturated_o,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [ccd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ccd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  import ccd_pkg::*;

  // Configuration registers
  logic [INV_W-1:0]   inv_x_q, inv_y_q;
  logic [START_W-1:0] start_x_q, start_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q   <= INV_RESET;
      inv_y_q   <= INV_RESET;
      start_x_q <= START_RESET;
      start_y_q <= START_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INV_X:   inv_x_q   <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_Y:   inv_y_q   <= cfg_wdata_i[INV_W-1:0];
        CFG_START_X: start_x_q <= cfg_wdata_i[START_W-1:0];
        CFG_START_Y: start_y_q <= cfg_wdata_i[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  ctl_t  ctl;
  stat_t stat;
  res_t  res;
  logic  accept;
  logic  pend_q, pend_d;

  assign in_stall_o = !(ctl.in_rdy && !pend_q);
  assign accept     = in_valid_i && !in_stall_o;

  ccd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .stat_i   (stat),
    .ctl_o    (ctl)
  );

  ccd_datapath #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .accept_i          (accept),
    .req_type_i        (req_type_i),
    .x_pos_i           (x_pos_i),
    .y_pos_i           (y_pos_i),
    .particle_weight_i (particle_weight_i),
    .read_col_i        (read_col_i),
    .read_row_i        (read_row_i),
    .inv_x_i           (inv_x_q),
    .inv_y_i           (inv_y_q),
    .start_x_i         (start_x_q),
    .start_y_i         (start_y_q),
    .stat_o            (stat),
    .res_o             (res)
  );

  // Output register; a finished result waits as pending while it is full and stalled
  logic             out_valid_q, out_valid_d;
  logic             out_free, load_out;
  logic [ACC_W-1:0] value_q;
  logic             oor_q, sat_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (ctl.finish || pend_q) && out_free;
  assign pend_d      = (ctl.finish || pend_q) && !out_free;
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q <= res.value;
      oor_q   <= res.oor;
      sat_q   <= res.sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_value_o   = value_q;
  assign out_of_range_o = oor_q;
  assign saturated_o    = sat_q;

endmodule

`default_nettype wire
